[rtl/core/sst_pkg.sv]
// sst_pkg: shared codes and types for the sorted score table
// request and status codes, cell operation codes, per-cell control struct
// no dependencies
`timescale 1ns / 1ps

package sst_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 32;
	localparam int KEY_BITS_DEF   = 32;
	localparam int SCORE_BITS_DEF = 16;

	// request codes
	localparam int REQ_W = 3;
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LIST   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LOWEST = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SAME   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_BACK   = 3'd5;

	// status codes
	localparam int STAT_W = 3;
	localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd0;
	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd1;
	localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_NONE      = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

	// cell operations
	localparam int CELL_OP_W = 3;
	localparam logic [CELL_OP_W-1:0] CELL_HOLD  = 3'd0;
	localparam logic [CELL_OP_W-1:0] CELL_LEFT  = 3'd1;
	localparam logic [CELL_OP_W-1:0] CELL_RIGHT = 3'd2;
	localparam logic [CELL_OP_W-1:0] CELL_INS   = 3'd3;
	localparam logic [CELL_OP_W-1:0] CELL_REM   = 3'd4;

	typedef struct packed {
		logic [CELL_OP_W-1:0] op;
		logic                 live;  // cell holds a table entry
		logic                 rm;    // cell closes the gap on removal
	} cell_ctl_t;

endpackage

[rtl/core/sst_cell.sv]
// sst_cell: one slot of the score table ring
// holds a key and a score, shifts to either neighbor, inserts in place
// depends on sst_pkg
`timescale 1ns / 1ps

module sst_cell import sst_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF,
	parameter bit HEAD       = 1'b0
) (
	input  logic                         clk,
	input  cell_ctl_t                    ctl,
	input  logic [KEY_BITS-1:0]          new_key,
	input  logic signed [SCORE_BITS-1:0] new_score,
	input  logic [KEY_BITS-1:0]          lft_key,
	input  logic signed [SCORE_BITS-1:0] lft_score,
	input  logic                         lft_ge,
	input  logic [KEY_BITS-1:0]          rgt_key,
	input  logic signed [SCORE_BITS-1:0] rgt_score,
	output logic [KEY_BITS-1:0]          key,
	output logic signed [SCORE_BITS-1:0] score,
	output logic                         ge
);

	logic [KEY_BITS-1:0]          key_q;
	logic signed [SCORE_BITS-1:0] score_q;

	// insert point is at or before this slot; head only yields on strictly greater
	assign ge = !ctl.live || (score_q > new_score) || (!HEAD && (score_q == new_score));

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_LEFT: begin
				key_q   <= rgt_key;
				score_q <= rgt_score;
			end
			CELL_RIGHT: begin
				key_q   <= lft_key;
				score_q <= lft_score;
			end
			CELL_INS: begin
				if (lft_ge) begin
					key_q   <= lft_key;
					score_q <= lft_score;
				end else if (ge) begin
					key_q   <= new_key;
					score_q <= new_score;
				end
			end
			CELL_REM: begin
				if (ctl.rm) begin
					key_q   <= rgt_key;
					score_q <= rgt_score;
				end
			end
			default: begin
			end
		endcase
	end

	assign key   = key_q;
	assign score = score_q;

endmodule

[rtl/core/sorted_score_table_top.sv]
// sorted_score_table_top: sorted score table built as a ring of cells
// sequencer, output register and the cell ring
// depends on sst_pkg and sst_cell
`timescale 1ns / 1ps

// The table keeps up to DEPTH entries (key, signed score) in ascending score
// order in a ring of DEPTH cells; cell 0 holds the head between requests.
// One request is taken at a time and in_stall stays high until its last word
// has been handed to the output register and the ring is back home; the
// output register lets the next request in while that word still waits on
// out_stall. Add and lowest are accepted, then done in S_ONE. List all and
// same score rotate the ring one cell per cycle, reading cell 0, through
// every entry (same score then flushes its last hit), then rotate home the
// shorter way round and drop back to idle. Delete and backward search rotate
// until the key reaches cell 0 or every entry has been passed, then act on
// the hit; backward then walks back one entry per cycle, reading cell
// DEPTH-1, and delete closes the gap as it reports the hit and rotates home.
// The single read point of the ring sets how long a request runs. Each word
// step, and with it the rotation of list, search and backward walk, waits
// while the output register is full and stalled.

module sorted_score_table_top import sst_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [REQ_W-1:0]             req_type,
	input  logic [KEY_BITS-1:0]          name_key,
	input  logic signed [SCORE_BITS-1:0] score,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [STAT_W-1:0]            status,
	output logic [KEY_BITS-1:0]          entry_key,
	output logic signed [SCORE_BITS-1:0] entry_score,
	output logic                         last
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ONE     = 3'd1;  // add or lowest, one word
	localparam logic [2:0] S_SEARCH  = 3'd2;  // rotate until key at cell 0
	localparam logic [2:0] S_LIST    = 3'd3;  // rotate and report cell 0
	localparam logic [2:0] S_BACK    = 3'd4;  // rotate back, report cell DEPTH-1
	localparam logic [2:0] S_RESTORE = 3'd5;  // rotate home

	logic [2:0]                   state_q, state_d;
	logic [REQ_W-1:0]             req_q;
	logic [KEY_BITS-1:0]          rkey_q;
	logic signed [SCORE_BITS-1:0] rscore_q;
	logic [CNT_W-1:0]             count_q, count_d;
	// number of left rotations the ring is away from home
	logic [CNT_W-1:0]             off_q, off_d;

	// pending same-score hit, held back until the next hit or end of scan
	logic                         pend_v_q;
	logic [KEY_BITS-1:0]          pend_key_q;
	logic signed [SCORE_BITS-1:0] pend_score_q;
	logic                         pend_ld, pend_clr;

	// output register
	logic                         out_valid_q;
	logic [STAT_W-1:0]            status_q;
	logic [KEY_BITS-1:0]          entry_key_q;
	logic signed [SCORE_BITS-1:0] entry_score_q;
	logic                         last_q;

	// word about to be written to the output register
	logic                         em;
	logic [STAT_W-1:0]            em_status;
	logic [KEY_BITS-1:0]          em_key;
	logic signed [SCORE_BITS-1:0] em_score;
	logic                         em_last;

	logic                         emit_ok;
	logic                         accept;
	logic [CELL_OP_W-1:0]         cell_op;
	logic [CNT_W-1:0]             rm_lim;

	// cell ring
	logic [KEY_BITS-1:0]          c_key   [DEPTH];
	logic signed [SCORE_BITS-1:0] c_score [DEPTH];
	logic                         c_ge    [DEPTH];
	cell_ctl_t                    c_ctl   [DEPTH];

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign emit_ok  = !out_valid_q || !out_stall;
	// cells below this index pull from the right on removal
	assign rm_lim   = count_q - off_q - CNT_W'(1);

	// sequencer
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		off_d     = off_q;
		cell_op   = CELL_HOLD;
		pend_ld   = 1'b0;
		pend_clr  = 1'b0;
		em        = 1'b0;
		em_status = ST_ENTRY;
		em_key    = '0;
		em_score  = '0;
		em_last   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (req_type)
						REQ_ADD, REQ_LOWEST:  state_d = S_ONE;
						REQ_DELETE, REQ_BACK: state_d = S_SEARCH;
						REQ_LIST, REQ_SAME:   state_d = S_LIST;
						default:              state_d = S_IDLE;
					endcase
				end
			end

			S_ONE: begin
				if (emit_ok) begin
					em      = 1'b1;
					em_last = 1'b1;
					state_d = S_IDLE;
					if (req_q == REQ_ADD) begin
						if (count_q == CNT_W'(DEPTH)) begin
							em_status = ST_FULL;
						end else begin
							cell_op   = CELL_INS;
							count_d   = count_q + CNT_W'(1);
							em_status = ST_ADDED;
						end
					end else if (count_q == '0) begin
						em_status = ST_NONE;
					end else begin
						em_key   = c_key[0];
						em_score = c_score[0];
					end
				end
			end

			S_SEARCH: begin
				if (emit_ok) begin
					if (off_q == count_q) begin
						// went past every entry without a hit
						em        = 1'b1;
						em_status = ST_NOT_FOUND;
						em_last   = 1'b1;
						state_d   = S_RESTORE;
					end else if (c_key[0] == rkey_q) begin
						if (req_q == REQ_DELETE) begin
							cell_op   = CELL_REM;
							count_d   = count_q - CNT_W'(1);
							em        = 1'b1;
							em_status = ST_DELETED;
							em_last   = 1'b1;
							state_d   = S_RESTORE;
						end else if (off_q == '0) begin
							// hit on the head: nothing in front of it
							em        = 1'b1;
							em_status = ST_NONE;
							em_last   = 1'b1;
							state_d   = S_IDLE;
						end else begin
							state_d = S_BACK;
						end
					end else begin
						cell_op = CELL_LEFT;
						off_d   = off_q + CNT_W'(1);
					end
				end
			end

			S_LIST: begin
				if (emit_ok) begin
					if (off_q == count_q) begin
						// scan over: flush the held hit or report empty
						em       = 1'b1;
						em_last  = 1'b1;
						pend_clr = 1'b1;
						state_d  = S_RESTORE;
						if (req_q == REQ_SAME && pend_v_q) begin
							em_key   = pend_key_q;
							em_score = pend_score_q;
						end else begin
							em_status = ST_NONE;
						end
					end else begin
						cell_op = CELL_LEFT;
						off_d   = off_q + CNT_W'(1);
						if (req_q == REQ_LIST) begin
							em       = 1'b1;
							em_key   = c_key[0];
							em_score = c_score[0];
							em_last  = (off_q + CNT_W'(1) == count_q);
							if (em_last) begin
								state_d = S_RESTORE;
							end
						end else if (c_score[0] == rscore_q) begin
							pend_ld  = 1'b1;
							em       = pend_v_q;
							em_key   = pend_key_q;
							em_score = pend_score_q;
						end
					end
				end
			end

			S_BACK: begin
				if (emit_ok) begin
					em       = 1'b1;
					em_key   = c_key[DEPTH-1];
					em_score = c_score[DEPTH-1];
					em_last  = (off_q == CNT_W'(1));
					cell_op  = CELL_RIGHT;
					off_d    = off_q - CNT_W'(1);
					if (em_last) begin
						state_d = S_IDLE;
					end
				end
			end

			S_RESTORE: begin
				if (off_q == '0 || off_q == CNT_W'(DEPTH)) begin
					off_d   = '0;
					state_d = S_IDLE;
				end else if (off_q > CNT_W'(DEPTH) - off_q) begin
					// nearer to go round the rest of the ring
					cell_op = CELL_LEFT;
					off_d   = off_q + CNT_W'(1);
				end else begin
					cell_op = CELL_RIGHT;
					off_d   = off_q - CNT_W'(1);
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			off_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			off_q    <= off_d;
			if (pend_clr) begin
				pend_v_q <= 1'b0;
			end else if (pend_ld) begin
				pend_v_q <= 1'b1;
			end
			if (em) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, pending hit and output word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			rkey_q   <= name_key;
			rscore_q <= score;
		end
		if (pend_ld) begin
			pend_key_q   <= c_key[0];
			pend_score_q <= c_score[0];
		end
		if (em) begin
			status_q      <= em_status;
			entry_key_q   <= em_key;
			entry_score_q <= em_score;
			last_q        <= em_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_key   = entry_key_q;
	assign entry_score = entry_score_q;
	assign last        = last_q;

	// ring of cells: left neighbor of cell 0 is the tail cell and vice versa
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int LFT = (i + DEPTH - 1) % DEPTH;
		localparam int RGT = (i + 1) % DEPTH;

		assign c_ctl[i].op   = cell_op;
		assign c_ctl[i].live = (CNT_W'(i) < count_q);
		assign c_ctl[i].rm   = (CNT_W'(i) < rm_lim);

		sst_cell #(
			.KEY_BITS   (KEY_BITS),
			.SCORE_BITS (SCORE_BITS),
			.HEAD       (i == 0)
		) u_cell (
			.clk       (clk),
			.ctl       (c_ctl[i]),
			.new_key   (rkey_q),
			.new_score (rscore_q),
			.lft_key   (c_key[LFT]),
			.lft_score (c_score[LFT]),
			.lft_ge    ((i == 0) ? 1'b0 : c_ge[LFT]),
			.rgt_key   (c_key[RGT]),
			.rgt_score (c_score[RGT]),
			.key       (c_key[i]),
			.score     (c_score[i]),
			.ge        (c_ge[i])
		);
	end

	// ring offset never runs past one full turn
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= CNT_W'(DEPTH))
		else $error("ring offset out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count out of range");

	// every request leaves the head back in cell 0
	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (off_q == '0))
		else $error("ring not home while idle");

	a_back_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BACK) |-> (off_q != '0))
		else $error("backward walk past the head");

	// status words carry no entry and close the request
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_ENTRY) |->
			(entry_key_q == '0 && entry_score_q == '0 && last_q))
		else $error("status word with entry payload");

endmodule

[sim/score_table_checker.sv]
// score_table_checker: watches both channels of the sorted score table,
// keeps its own copy of the table, predicts every result word and compares
// depends on sst_pkg
`timescale 1ns / 1ps

module score_table_checker import sst_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [REQ_W-1:0]             req_type,
	input  logic [KEY_BITS-1:0]          name_key,
	input  logic signed [SCORE_BITS-1:0] score,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [STAT_W-1:0]            status,
	input  logic [KEY_BITS-1:0]          entry_key,
	input  logic signed [SCORE_BITS-1:0] entry_score,
	input  logic                         last,
	output int                           errors,
	output int                           waiting
);

	typedef struct {
		logic [STAT_W-1:0]             st;
		logic [KEY_BITS-1:0]           key;
		logic signed [SCORE_BITS-1:0]  sc;
		logic                          fin;
	} result_word_t;

	result_word_t                 pending_words[$];
	result_word_t                 want;
	logic [KEY_BITS-1:0]          slot_key   [DEPTH];
	logic signed [SCORE_BITS-1:0] slot_score [DEPTH];
	int                           slot_count = 0;
	int                           mismatches = 0;

	initial begin
		errors = 0;
		waiting = 0;
	end

	function automatic void queue_word(logic [STAT_W-1:0] st, logic [KEY_BITS-1:0] k,
			logic signed [SCORE_BITS-1:0] s, logic fin);
		result_word_t w;
		w.st = st;
		w.key = k;
		w.sc = s;
		w.fin = fin;
		pending_words.push_back(w);
	endfunction

	function automatic int first_with_key(logic [KEY_BITS-1:0] k);
		int i;
		for (i = 0; i < slot_count; i++)
			if (slot_key[i] == k)
				return i;
		return -1;
	endfunction

	// table update and result words for one accepted request
	function automatic void apply_request(logic [REQ_W-1:0] req, logic [KEY_BITS-1:0] k,
			logic signed [SCORE_BITS-1:0] s);
		int i;
		int pos;
		int idx;
		int hits;
		int seen;
		case (req)
			REQ_ADD: begin
				if (slot_count >= DEPTH) begin
					queue_word(ST_FULL, '0, '0, 1'b1);
				end else begin
					// equal to the head: lands right after it
					if (slot_count == 0 || s < slot_score[0]) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < slot_count && slot_score[pos] < s)
							pos++;
					end
					for (i = slot_count; i > pos; i--) begin
						slot_key[i] = slot_key[i-1];
						slot_score[i] = slot_score[i-1];
					end
					slot_key[pos] = k;
					slot_score[pos] = s;
					slot_count++;
					queue_word(ST_ADDED, '0, '0, 1'b1);
				end
			end
			REQ_DELETE: begin
				idx = first_with_key(k);
				if (idx < 0) begin
					queue_word(ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					for (i = idx; i + 1 < slot_count; i++) begin
						slot_key[i] = slot_key[i+1];
						slot_score[i] = slot_score[i+1];
					end
					slot_count--;
					queue_word(ST_DELETED, '0, '0, 1'b1);
				end
			end
			REQ_LIST: begin
				for (i = 0; i < slot_count; i++)
					queue_word(ST_ENTRY, slot_key[i], slot_score[i], i + 1 == slot_count);
				if (slot_count == 0)
					queue_word(ST_NONE, '0, '0, 1'b1);
			end
			REQ_LOWEST: begin
				if (slot_count == 0)
					queue_word(ST_NONE, '0, '0, 1'b1);
				else
					queue_word(ST_ENTRY, slot_key[0], slot_score[0], 1'b1);
			end
			REQ_SAME: begin
				hits = 0;
				for (i = 0; i < slot_count; i++)
					if (slot_score[i] == s)
						hits++;
				seen = 0;
				for (i = 0; i < slot_count; i++) begin
					if (slot_score[i] == s) begin
						seen++;
						queue_word(ST_ENTRY, slot_key[i], slot_score[i], seen == hits);
					end
				end
				if (hits == 0)
					queue_word(ST_NONE, '0, '0, 1'b1);
			end
			REQ_BACK: begin
				idx = first_with_key(k);
				if (idx < 0) begin
					queue_word(ST_NOT_FOUND, '0, '0, 1'b1);
				end else if (idx == 0) begin
					queue_word(ST_NONE, '0, '0, 1'b1);
				end else begin
					for (i = idx; i > 0; i--)
						queue_word(ST_ENTRY, slot_key[i-1], slot_score[i-1], i == 1);
				end
			end
			default: ;  // spare codes are ignored
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count = 0;
			mismatches = 0;
			pending_words.delete();
			errors <= 0;
			waiting <= 0;
		end else begin
			// a result word never belongs to a request taken at the same edge
			if (out_valid && !out_stall) begin
				if (pending_words.size() == 0) begin
					mismatches++;
					// fields: status key score last
					$display("%0t: word with none expected: got %0d %h %0d %b",
						$time, status, entry_key, entry_score, last);
				end else begin
					want = pending_words.pop_front();
					if (status !== want.st || entry_key !== want.key ||
							entry_score !== want.sc || last !== want.fin) begin
						mismatches++;
						// fields: status key score last
						$display("%0t: mismatch: expected %0d %h %0d %b, got %0d %h %0d %b",
							$time, want.st, want.key, want.sc, want.fin,
							status, entry_key, entry_score, last);
					end
				end
			end
			if (in_valid && !in_stall)
				apply_request(req_type, name_key, score);
			errors <= mismatches;
			waiting <= pending_words.size();
		end
	end

endmodule

[sim/tb_sorted_score_table_top.sv]
// tb_sorted_score_table_top: stimulus and verdict for the sorted score table
// drives requests, stalls the result channel, checking lives in score_table_checker
// depends on sst_pkg, sorted_score_table_top and score_table_checker
`timescale 1ns / 1ps

module tb_sorted_score_table_top;
	import sst_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int KEY_BITS   = KEY_BITS_DEF;
	localparam int SCORE_BITS = SCORE_BITS_DEF;

	// request codes the block leaves unused
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam int RANDOM_WORDS = 280;
	localparam int POOL_SIZE    = 24;
	// worst request walks the ring out and home again
	localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [REQ_W-1:0]             req_type = REQ_LOWEST;
	logic [KEY_BITS-1:0]          name_key = '0;
	logic signed [SCORE_BITS-1:0] score = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [STAT_W-1:0]            status;
	logic [KEY_BITS-1:0]          entry_key;
	logic signed [SCORE_BITS-1:0] entry_score;
	logic                         last;

	int errors;
	int waiting;

	// keys reused on purpose so deletes and backward walks find entries;
	// slot 0 and 1 hold the all-zero and all-one keys
	logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

	// calm modes give stretches with no idling on either side
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int unsigned rx_hold = 0;
	int unsigned step;

	sorted_score_table_top #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.SCORE_BITS(SCORE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.name_key(name_key),
		.score(score),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_key(entry_key),
		.entry_score(entry_score),
		.last(last)
	);

	score_table_checker #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.SCORE_BITS(SCORE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.name_key(name_key),
		.score(score),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_key(entry_key),
		.entry_score(entry_score),
		.last(last),
		.errors(errors),
		.waiting(waiting)
	);

	always #5 clk = ~clk;

	// result side: after each taken word raise stall for a random hold (none in calm mode),
	// so stalls land on first, middle and last words alike
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if ($urandom_range(0, 29) == 0)
					rx_calm = !rx_calm;
				rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
			end else if (rx_hold != 0) begin
				rx_hold = rx_hold - 1;
			end
			out_stall <= (rx_hold != 0);
		end
	end

	// one request word: optional idle gap first, then hold it until taken;
	// valid is only lowered on a gap, so back-to-back words keep it high
	task automatic issue_request(input logic [REQ_W-1:0] req, input logic [KEY_BITS-1:0] k,
			input logic signed [SCORE_BITS-1:0] s);
		int unsigned gap;
		if ($urandom_range(0, 24) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		name_key <= k;
		score <= s;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending until every predicted word has come back
	task automatic wait_table_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return KEY_BITS'($urandom);  // most likely absent from the table
		return key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// extremes, a narrow band for equal scores, and the full range
	function automatic logic signed [SCORE_BITS-1:0] pick_score();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(SCORE_BITS-1){1'b0}}};
			1: return {1'b0, {(SCORE_BITS-1){1'b1}}};
			2, 3, 4, 5: return SCORE_BITS'(int'($urandom_range(0, 6)) - 3);
			default: return SCORE_BITS'($urandom);
		endcase
	endfunction

	// opening adds always fill the table past full; a later stretch
	// leans on deletes to drain it; the rest is a mix weighted toward adds
	task automatic issue_random(input int unsigned idx);
		int unsigned roll;
		logic [REQ_W-1:0] req;
		roll = $urandom_range(0, 99);
		if (idx < 40)
			req = REQ_ADD;
		else if (idx >= 200 && idx < 250)
			req = (roll < 60) ? REQ_DELETE : (roll < 70) ? REQ_ADD : (roll < 78) ? REQ_LIST :
				(roll < 84) ? REQ_LOWEST : (roll < 92) ? REQ_SAME : REQ_BACK;
		else
			req = (roll < 30) ? REQ_ADD : (roll < 50) ? REQ_DELETE : (roll < 60) ? REQ_LIST :
				(roll < 70) ? REQ_LOWEST : (roll < 85) ? REQ_SAME : REQ_BACK;
		issue_request(req, pick_key(), pick_score());
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_BITS'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty table: every query has nothing to show or finds nothing
		issue_request(REQ_LOWEST, '0, '0);
		issue_request(REQ_LIST, '0, '0);
		issue_request(REQ_SAME, '0, '0);
		issue_request(REQ_DELETE, key_pool[2], '0);
		issue_request(REQ_BACK, key_pool[2], '0);
		// build a small table at the score extremes
		issue_request(REQ_ADD, key_pool[0], 16'sd0);
		issue_request(REQ_ADD, key_pool[1], -16'sd32768);
		issue_request(REQ_ADD, key_pool[2], 16'sd32767);
		// equal scores deeper in the table go in front of the equals
		issue_request(REQ_ADD, key_pool[3], 16'sd0);
		// equal to the head goes right behind the head
		issue_request(REQ_ADD, key_pool[4], -16'sd32768);
		issue_request(REQ_LIST, '0, '0);
		issue_request(REQ_LOWEST, '0, '0);
		issue_request(REQ_SAME, '0, 16'sd0);
		issue_request(REQ_SAME, '0, -16'sd32768);
		issue_request(REQ_SAME, '0, 16'sd5);
		// backward from the head has nothing in front of it
		issue_request(REQ_BACK, key_pool[1], '0);
		issue_request(REQ_BACK, key_pool[2], '0);
		issue_request(REQ_BACK, 32'h1234_5678, '0);
		// spare codes must produce nothing
		issue_request(REQ_SPARE_LO, key_pool[2], 16'sd1);
		issue_request(REQ_SPARE_HI, '1, '1);
		issue_request(REQ_DELETE, key_pool[0], '0);
		issue_request(REQ_DELETE, 32'h1234_5678, '0);
		issue_request(REQ_LIST, '0, '0);
		wait_table_quiet();

		step = 0;
		while (step < RANDOM_WORDS) begin
			if ($urandom_range(0, 24) == 0) begin
				// spare codes are noise and do not count
				issue_request($urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO,
					pick_key(), pick_score());
			end else begin
				issue_random(step);
				step++;
				// sender holds off until the table has answered everything
				if (step == 120 || step == 200)
					wait_table_quiet();
			end
		end

		wait_table_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("sorted_score_table_top regression: pass");
		else
			$display("sorted_score_table_top regression: fail");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#6_000_000;
		$display("sorted_score_table_top regression: fail");
		$finish;
	end

endmodule
